[rtl/bqf_pkg.sv]
`default_nettype none
package bqf_pkg;

   localparam int COEF_FRAC_BITS = 15;
   localparam int SAMPLE_WIDTH = 16;

   localparam int COEF_WIDTH = 18;
   localparam int DELAY_WIDTH = 48;
   localparam int OUT_WIDTH = 18;
   localparam int CSR_INDEX_WIDTH = 3;

   // s = b0*x + delay_first, split in two for the shared multiplier
   localparam int S_WIDTH = DELAY_WIDTH + 1;
   localparam int LO_WIDTH = 24;
   localparam int MUL_B_WIDTH = S_WIDTH - LO_WIDTH;
   localparam int PROD_WIDTH = COEF_WIDTH + MUL_B_WIDTH;
   localparam int FULL_WIDTH = COEF_WIDTH + S_WIDTH;
   localparam int FB_WIDTH = FULL_WIDTH - COEF_FRAC_BITS;
   localparam int ACC_WIDTH = ((FB_WIDTH > DELAY_WIDTH) ? FB_WIDTH : DELAY_WIDTH) + 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_A1 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_A2 = 3'd4;

   localparam logic signed [COEF_WIDTH-1:0] B0_RESET = 18'sd32768;

   typedef enum logic [2:0] {
      SEL_B0,
      SEL_B1,
      SEL_B2,
      SEL_A1,
      SEL_A2
   } coef_sel_type;

   typedef enum logic [1:0] {
      SEL_X,
      SEL_S_LO,
      SEL_S_HI
   } operand_sel_type;

   typedef struct packed {
      coef_sel_type    mul_a_sel;
      operand_sel_type mul_b_sel;
      logic            take_sample;
      logic            load_s;
      logic            load_acc1;
      logic            load_acc2;
      logic            load_lo;
      logic            load_fb;
      logic            sub_acc1;
      logic            finish;
   } cmd_type;

   function automatic logic signed [DELAY_WIDTH-1:0] sat_delay(
      input logic signed [ACC_WIDTH-1:0] v
   );
      logic signed [ACC_WIDTH-1:0] hi;
      logic signed [ACC_WIDTH-1:0] lo;
      hi = {{(ACC_WIDTH-DELAY_WIDTH+1){1'b0}}, {(DELAY_WIDTH-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[DELAY_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[DELAY_WIDTH-1:0];
      end
      return v[DELAY_WIDTH-1:0];
   endfunction

   function automatic logic signed [OUT_WIDTH-1:0] sat_out(
      input logic signed [S_WIDTH-1:0] s
   );
      logic signed [S_WIDTH-1:0] sh;
      logic signed [S_WIDTH-1:0] hi;
      logic signed [S_WIDTH-1:0] lo;
      sh = s >>> COEF_FRAC_BITS;
      hi = {{(S_WIDTH-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
      lo = ~hi;
      if (sh > hi) begin
         return hi[OUT_WIDTH-1:0];
      end else if (sh < lo) begin
         return lo[OUT_WIDTH-1:0];
      end
      return sh[OUT_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/bqf_ctrl.sv]
`default_nettype none
module bqf_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output bqf_pkg::cmd_type     cmd
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_MB0  = 10'b0000000010,
      ST_MB1  = 10'b0000000100,
      ST_MB2  = 10'b0000001000,
      ST_MA1L = 10'b0000010000,
      ST_MA1H = 10'b0000100000,
      ST_MA2L = 10'b0001000000,
      ST_MA2H = 10'b0010000000,
      ST_FB2  = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      open_slot;
   logic      accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign open_slot = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign accept = req_valid && open_slot;
   assign req_stall = !open_slot;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.mul_a_sel = bqf_pkg::SEL_B0;
      cmd.mul_b_sel = bqf_pkg::SEL_X;
      cmd.take_sample = accept;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MB0;
            end
         end
         ST_MB0: begin
            state_in = ST_MB1;
         end
         ST_MB1: begin
            cmd.mul_a_sel = bqf_pkg::SEL_B1;
            cmd.load_s = 1'b1;
            state_in = ST_MB2;
         end
         ST_MB2: begin
            cmd.mul_a_sel = bqf_pkg::SEL_B2;
            cmd.load_acc1 = 1'b1;
            state_in = ST_MA1L;
         end
         ST_MA1L: begin
            cmd.mul_a_sel = bqf_pkg::SEL_A1;
            cmd.mul_b_sel = bqf_pkg::SEL_S_LO;
            cmd.load_acc2 = 1'b1;
            state_in = ST_MA1H;
         end
         ST_MA1H: begin
            cmd.mul_a_sel = bqf_pkg::SEL_A1;
            cmd.mul_b_sel = bqf_pkg::SEL_S_HI;
            cmd.load_lo = 1'b1;
            state_in = ST_MA2L;
         end
         ST_MA2L: begin
            cmd.mul_a_sel = bqf_pkg::SEL_A2;
            cmd.mul_b_sel = bqf_pkg::SEL_S_LO;
            cmd.load_fb = 1'b1;
            state_in = ST_MA2H;
         end
         ST_MA2H: begin
            cmd.mul_a_sel = bqf_pkg::SEL_A2;
            cmd.mul_b_sel = bqf_pkg::SEL_S_HI;
            cmd.load_lo = 1'b1;
            cmd.sub_acc1 = 1'b1;
            state_in = ST_FB2;
         end
         ST_FB2: begin
            cmd.load_fb = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in = accept ? ST_MB0 : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[rtl/bqf_datapath.sv]
`default_nettype none
module bqf_datapath (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire bqf_pkg::cmd_type                              cmd,
   input  wire logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]       req_sample_in,
   input  wire logic                                          csr_valid,
   input  wire logic [bqf_pkg::CSR_INDEX_WIDTH-1:0]           csr_index,
   input  wire logic signed [bqf_pkg::COEF_WIDTH-1:0]         csr_wdata,
   output logic signed [bqf_pkg::OUT_WIDTH-1:0]               rsp_sample_out
);

   logic signed [bqf_pkg::COEF_WIDTH-1:0]  b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] x_ff;
   logic signed [bqf_pkg::DELAY_WIDTH-1:0] d1_ff, d2_ff;
   logic signed [bqf_pkg::DELAY_WIDTH-1:0] d1_in, d2_in;
   logic signed [bqf_pkg::S_WIDTH-1:0]     s_ff;
   logic signed [bqf_pkg::PROD_WIDTH-1:0]  prod_ff;
   logic signed [bqf_pkg::PROD_WIDTH-1:0]  lo_ff;
   logic signed [bqf_pkg::ACC_WIDTH-1:0]   acc1_ff, acc2_ff, fb_ff;
   logic signed [bqf_pkg::OUT_WIDTH-1:0]   out_ff;
   logic signed [bqf_pkg::COEF_WIDTH-1:0]  mul_a;
   logic signed [bqf_pkg::MUL_B_WIDTH-1:0] mul_b;
   logic signed [bqf_pkg::S_WIDTH-1:0]     prod_s;
   logic signed [bqf_pkg::ACC_WIDTH-1:0]   prod_acc;
   logic signed [bqf_pkg::ACC_WIDTH-1:0]   d2_acc;
   logic signed [bqf_pkg::S_WIDTH-1:0]     d1_s;
   logic signed [bqf_pkg::FULL_WIDTH-1:0]  full;
   logic signed [bqf_pkg::ACC_WIDTH-1:0]   fb_in;
   logic                                   clear_delays;

   assign rsp_sample_out = out_ff;

   always_comb begin
      case (cmd.mul_a_sel)
         bqf_pkg::SEL_B0: mul_a = b0_ff;
         bqf_pkg::SEL_B1: mul_a = b1_ff;
         bqf_pkg::SEL_B2: mul_a = b2_ff;
         bqf_pkg::SEL_A1: mul_a = a1_ff;
         bqf_pkg::SEL_A2: mul_a = a2_ff;
         default:         mul_a = b0_ff;
      endcase
      case (cmd.mul_b_sel)
         bqf_pkg::SEL_X: mul_b = {{(bqf_pkg::MUL_B_WIDTH-bqf_pkg::SAMPLE_WIDTH)
                                   {x_ff[bqf_pkg::SAMPLE_WIDTH-1]}}, x_ff};
         bqf_pkg::SEL_S_LO: mul_b = {1'b0, s_ff[bqf_pkg::LO_WIDTH-1:0]};
         bqf_pkg::SEL_S_HI: mul_b = s_ff[bqf_pkg::S_WIDTH-1:bqf_pkg::LO_WIDTH];
         default: mul_b = '0;
      endcase
   end

   // sign extensions of the registered product and the delays
   assign prod_s = {{(bqf_pkg::S_WIDTH-bqf_pkg::PROD_WIDTH)
                     {prod_ff[bqf_pkg::PROD_WIDTH-1]}}, prod_ff};
   assign prod_acc = {{(bqf_pkg::ACC_WIDTH-bqf_pkg::PROD_WIDTH)
                       {prod_ff[bqf_pkg::PROD_WIDTH-1]}}, prod_ff};
   assign d1_s = {d1_ff[bqf_pkg::DELAY_WIDTH-1], d1_ff};
   assign d2_acc = {{(bqf_pkg::ACC_WIDTH-bqf_pkg::DELAY_WIDTH)
                     {d2_ff[bqf_pkg::DELAY_WIDTH-1]}}, d2_ff};

   // high partial product shifted up plus the low partial product
   assign full = {prod_ff, {bqf_pkg::LO_WIDTH{1'b0}}}
               + {{(bqf_pkg::FULL_WIDTH-bqf_pkg::PROD_WIDTH)
                   {lo_ff[bqf_pkg::PROD_WIDTH-1]}}, lo_ff};
   assign fb_in = {{(bqf_pkg::ACC_WIDTH-bqf_pkg::FB_WIDTH)
                    {full[bqf_pkg::FULL_WIDTH-1]}},
                   full[bqf_pkg::FULL_WIDTH-1:bqf_pkg::COEF_FRAC_BITS]};

   always_comb begin
      clear_delays = 1'b0;
      if (csr_valid) begin
         unique case (csr_index) inside
            bqf_pkg::REG_B0, bqf_pkg::REG_B1, bqf_pkg::REG_B2,
            bqf_pkg::REG_A1, bqf_pkg::REG_A2: clear_delays = 1'b1;
            default: clear_delays = 1'b0;
         endcase
      end
      d1_in = d1_ff;
      d2_in = d2_ff;
      if (cmd.finish) begin
         d1_in = bqf_pkg::sat_delay(acc1_ff);
         d2_in = bqf_pkg::sat_delay(acc2_ff - fb_ff);
      end
      if (clear_delays) begin
         d1_in = '0;
         d2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= bqf_pkg::B0_RESET;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
         d1_ff <= '0;
         d2_ff <= '0;
      end else begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         if (csr_valid) begin
            case (csr_index)
               bqf_pkg::REG_B0: b0_ff <= csr_wdata;
               bqf_pkg::REG_B1: b1_ff <= csr_wdata;
               bqf_pkg::REG_B2: b2_ff <= csr_wdata;
               bqf_pkg::REG_A1: a1_ff <= csr_wdata;
               bqf_pkg::REG_A2: a2_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.take_sample) begin
         x_ff <= req_sample_in;
      end
      if (cmd.load_s) begin
         s_ff <= prod_s + d1_s;
      end
      if (cmd.load_acc1) begin
         acc1_ff <= prod_acc + d2_acc;
      end else if (cmd.sub_acc1) begin
         acc1_ff <= acc1_ff - fb_ff;
      end
      if (cmd.load_acc2) begin
         acc2_ff <= prod_acc;
      end
      if (cmd.load_lo) begin
         lo_ff <= prod_ff;
      end
      if (cmd.load_fb) begin
         fb_ff <= fb_in;
      end
      if (cmd.finish) begin
         out_ff <= bqf_pkg::sat_out(s_ff);
      end
   end

endmodule
`default_nettype wire

[rtl/fixed_point_biquad_filter.sv]
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_sample_in  (16 bit signed)
// rsp_      out        rsp_valid/rsp_stall  rsp_sample_out (18 bit signed)
// csr_      in         csr_valid/csr_ready  csr_index, csr_wdata (18 bit signed)
//
// one sample at a time, its products formed in turn on one shared 18x25 multiplier
// (three feedforward products, each feedback product in two halves of the
// 49-bit sum), then a step to fold the last feedback term and a step to write back
// rsp_valid is registered and rises at the end of the write-back step
// reset restores the coefficients and clears both delays, as does a coefficient write
// a result waiting under rsp_stall holds the next sample in its last step
`default_nettype none
module fixed_point_biquad_filter (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_stall,
   input  wire logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]    req_sample_in,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_stall,
   output logic signed [bqf_pkg::OUT_WIDTH-1:0]            rsp_sample_out,
   input  wire logic                                       csr_valid,
   output logic                                            csr_ready,
   input  wire logic [bqf_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  wire logic signed [bqf_pkg::COEF_WIDTH-1:0]      csr_wdata
);

   bqf_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   bqf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bqf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_sample_in  (req_sample_in),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_sample_out (rsp_sample_out)
   );

endmodule
`default_nettype wire

[sim/tb_fixed_point_biquad_filter.sv]
`timescale 1ns / 1ps
module tb_fixed_point_biquad_filter;

   typedef logic signed [127:0] wide_type;
   typedef logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [bqf_pkg::COEF_WIDTH-1:0] coef_type;
   typedef logic [bqf_pkg::CSR_INDEX_WIDTH-1:0] index_type;

   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 12;

   logic                                       clock;
   logic                                       reset;
   logic                                       req_valid;
   logic                                       req_stall;
   logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]    req_sample_in;
   logic                                       rsp_valid;
   logic                                       rsp_stall;
   logic signed [bqf_pkg::OUT_WIDTH-1:0]       rsp_sample_out;
   logic                                       csr_valid;
   logic                                       csr_ready;
   logic [bqf_pkg::CSR_INDEX_WIDTH-1:0]        csr_index;
   logic signed [bqf_pkg::COEF_WIDTH-1:0]      csr_wdata;

   logic signed [bqf_pkg::COEF_WIDTH-1:0]      gain [0:4];
   wide_type                                   tap_z1;
   wide_type                                   tap_z2;
   logic signed [bqf_pkg::OUT_WIDTH-1:0]       pending_out_q [$];
   logic signed [bqf_pkg::OUT_WIDTH-1:0]       want_out;
   int                                         fail_count = 0;
   int                                         idle_cycles = 0;
   bit                                         quiet = 1'b0;
   int                                         hold_requests = 0;
   int                                         holds_served = 0;

   fixed_point_biquad_filter i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic wide_type clamp_to(input wide_type v, input int w);
      wide_type one;
      wide_type hi;
      wide_type lo;
      one = wide_type'(1);
      hi = (one <<< (w - 1)) - one;
      lo = -hi - one;
      if (v > hi) begin
         return hi;
      end
      if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   function automatic void reset_filter_model();
      gain[bqf_pkg::REG_B0] = bqf_pkg::B0_RESET;
      gain[bqf_pkg::REG_B1] = '0;
      gain[bqf_pkg::REG_B2] = '0;
      gain[bqf_pkg::REG_A1] = '0;
      gain[bqf_pkg::REG_A2] = '0;
      tap_z1 = '0;
      tap_z2 = '0;
   endfunction

   function automatic logic signed [bqf_pkg::OUT_WIDTH-1:0] biquad_predict(
      input logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] x
   );
      wide_type xs;
      wide_type b0;
      wide_type b1;
      wide_type b2;
      wide_type a1;
      wide_type a2;
      wide_type s;
      wide_type n1;
      wide_type n2;
      wide_type y;
      xs = wide_type'(x);
      b0 = wide_type'(gain[bqf_pkg::REG_B0]);
      b1 = wide_type'(gain[bqf_pkg::REG_B1]);
      b2 = wide_type'(gain[bqf_pkg::REG_B2]);
      a1 = wide_type'(gain[bqf_pkg::REG_A1]);
      a2 = wide_type'(gain[bqf_pkg::REG_A2]);
      s = b0 * xs + tap_z1;
      n1 = b1 * xs - ((a1 * s) >>> bqf_pkg::COEF_FRAC_BITS) + tap_z2;
      n2 = b2 * xs - ((a2 * s) >>> bqf_pkg::COEF_FRAC_BITS);
      y = clamp_to(s >>> bqf_pkg::COEF_FRAC_BITS, bqf_pkg::OUT_WIDTH);
      tap_z1 = clamp_to(n1, bqf_pkg::DELAY_WIDTH);
      tap_z2 = clamp_to(n2, bqf_pkg::DELAY_WIDTH);
      return y[bqf_pkg::OUT_WIDTH-1:0];
   endfunction

   function automatic logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] pick_sample();
      case ($urandom_range(7))
         0: return sample_type'(-32768);
         1: return sample_type'(32767);
         2: return sample_type'(int'($urandom_range(255)) - 128);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic signed [bqf_pkg::COEF_WIDTH-1:0] pick_wild_coef();
      case ($urandom_range(9))
         0: return coef_type'(-131072);
         1: return coef_type'(131071);
         2: return coef_type'(0);
         default: return coef_type'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] x);
      while (!quiet && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_out_q.push_back(biquad_predict(x));
   endtask

   task automatic wait_block_idle();
      req_valid <= 1'b0;
      while (pending_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_coef(
      input logic [bqf_pkg::CSR_INDEX_WIDTH-1:0] idx,
      input logic signed [bqf_pkg::COEF_WIDTH-1:0] val
   );
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx <= bqf_pkg::REG_A2) begin
         gain[idx] = val;
         tap_z1 = '0;
         tap_z2 = '0;
      end
      @(posedge clock);
   endtask

   task automatic program_filter(
      input logic signed [bqf_pkg::COEF_WIDTH-1:0] b0,
      input logic signed [bqf_pkg::COEF_WIDTH-1:0] b1,
      input logic signed [bqf_pkg::COEF_WIDTH-1:0] b2,
      input logic signed [bqf_pkg::COEF_WIDTH-1:0] a1,
      input logic signed [bqf_pkg::COEF_WIDTH-1:0] a2
   );
      write_coef(bqf_pkg::REG_B0, b0);
      write_coef(bqf_pkg::REG_B1, b1);
      write_coef(bqf_pkg::REG_B2, b2);
      write_coef(bqf_pkg::REG_A1, a1);
      write_coef(bqf_pkg::REG_A2, a2);
   endtask

   // unity gain after reset
   task automatic test_reset_coefs();
      send_sample(0);
      send_sample(32767);
      send_sample(-32768);
      send_sample(1);
      send_sample(-1);
   endtask

   task automatic test_output_clamp();
      wait_block_idle();
      program_filter(131071, 0, 0, 0, 0);
      send_sample(32767);
      send_sample(-32768);
      wait_block_idle();
      write_coef(bqf_pkg::REG_B0, -131072);
      send_sample(-32768);
      send_sample(32767);
   endtask

   // runaway feedback drives both delays into their limits
   task automatic test_delay_clamp();
      wait_block_idle();
      program_filter(131071, 131071, 131071, -131072, -131072);
      repeat (7) send_sample(32767);
      repeat (2) send_sample(-32768);
   endtask

   // writes past the last register leave the delays alone
   task automatic test_spare_index();
      wait_block_idle();
      program_filter(20000, -12000, 5000, -15000, 8000);
      send_sample(12345);
      send_sample(-23456);
      wait_block_idle();
      write_coef(index_type'(bqf_pkg::REG_A2 + 1), coef_type'(131071));
      write_coef(index_type'(bqf_pkg::REG_A2 + 2), coef_type'(-131072));
      write_coef(index_type'(bqf_pkg::REG_A2 + 3), 18'sh2aaaa);
      send_sample(3000);
      send_sample(-7);
   endtask

   task automatic test_random_filters();
      int phase;
      int n;
      int count;
      bit wild;
      for (phase = 0; phase < 16; phase++) begin
         wait_block_idle();
         quiet = (phase == 5);
         wild = (phase % 4 == 3);
         if (wild) begin
            program_filter(pick_wild_coef(), pick_wild_coef(), pick_wild_coef(),
                           pick_wild_coef(), pick_wild_coef());
         end else begin
            program_filter(coef_type'(int'($urandom_range(65535)) - 32768),
                           coef_type'(int'($urandom_range(32767)) - 16384),
                           coef_type'(int'($urandom_range(32767)) - 16384),
                           coef_type'(int'($urandom_range(32768)) - 16384),
                           coef_type'(int'($urandom_range(32768)) - 16384));
         end
         if ($urandom_range(3) == 0) begin
            write_coef(index_type'(bqf_pkg::REG_A2 + 1 + $urandom_range(2)),
                       coef_type'($urandom));
         end
         count = quiet ? 60 : 20 + $urandom_range(20);
         for (n = 0; n < count; n++) begin
            send_sample(pick_sample());
         end
      end
      quiet = 1'b0;
   endtask

   // receiver holds off while samples keep coming
   task automatic test_backpressure();
      int n;
      wait_block_idle();
      program_filter(16384, 8192, -4096, -12000, 6000);
      hold_requests++;
      for (n = 0; n < 30; n++) begin
         send_sample(pick_sample());
      end
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 11);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_out_q.size() == 0) begin
            $error("unexpected result beat, sample_out %0d", rsp_sample_out);
            fail_count++;
         end else begin
            want_out = pending_out_q.pop_front();
            if (rsp_sample_out !== want_out) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      want_out, rsp_sample_out);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample_in <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      reset_filter_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_coefs();
      test_output_clamp();
      test_delay_clamp();
      test_spare_index();
      test_random_filters();
      test_backpressure();
      wait_block_idle();
      if (pending_out_q.size() != 0) begin
         $error("%0d expected results never arrived", pending_out_q.size());
      end
      if (fail_count == 0 && pending_out_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
